// File: design/bpdc_pkg.sv
package bpdc_pkg;

  // Internal widths of the pricing datapath.
  localparam int DATE_W   = 17;   // day numbers may run past 65535 without wrapping
  localparam int SUM_W    = 32;   // sum of factors over all kept dates
  localparam int PROD_W   = 46;   // coupon times sum
  localparam int NUM_W    = 48;   // dividend of the shared divider
  localparam int DEN_W    = 16;   // divisor of the shared divider
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int PRICE_W  = 40;   // unsaturated price

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FIRST_WAIT,
    ST_WALK,
    ST_DRAIN,
    ST_MUL_B,
    ST_GO_B,
    ST_WAIT_B,
    ST_MUL_U,
    ST_GO_U,
    ST_WAIT_U,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    DIV_FIRST,
    DIV_BASE,
    DIV_BUMP
  } div_kind_t;

  typedef struct packed {
    logic      capture;      // price word accepted: latch its fields
    logic      write_entry;  // load word accepted: write the curve
    logic      walk_step;    // look up the current date and advance
    logic      mul_en;       // form coupon times sum
    logic      mul_sel;      // 0 base curve, 1 bumped curve
    logic      div_start;
    div_kind_t div_kind;
    logic      finish;       // build and present the result word
  } cmd_t;

  typedef struct packed {
    logic before_today;
    logic last_date;
    logic div_done;
  } status_t;

endpackage

// File: design/bpdc_ram.sv
module bpdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/bpdc_div.sv
module bpdc_div import bpdc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  // Restoring division, one quotient bit per cycle.
  logic                 running;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W:0]       rem_sh;
  logic                 ge;
  logic [DEN_W:0]       rem_sub;

  always_comb begin
    rem_sh  = {rem, quo[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den};
    rem_sub = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == DIV_CNT_W'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      cnt <= DIV_CNT_W'(NUM_W);
    end else if (running) begin
      rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

endmodule

// File: design/bpdc_datapath.sv
module bpdc_datapath import bpdc_pkg::*; #(
  parameter int CURVE_DEPTH = 4096,
  parameter int YEAR_DAYS   = 365
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  input  logic [11:0]        day_offset,
  input  logic [15:0]        discount_factor,
  input  logic [15:0]        discount_factor_bumped,
  input  logic [13:0]        coupon_centipct,
  input  logic [3:0]         pay_freq,
  input  logic [15:0]        anchor_day,
  input  logic [15:0]        maturity_day,
  output logic               done,
  output logic [31:0]        price,
  output logic signed [31:0] dv01,
  output logic               out_of_range
);

  localparam int AW = $clog2(CURVE_DEPTH);
  localparam logic [DATE_W:0] DEPTH_W = (DATE_W + 1)'(CURVE_DEPTH);

  logic [15:0]        today;
  logic [13:0]        coupon_r;
  logic [3:0]         cpy_r;
  logic [8:0]         step_r;
  logic [15:0]        start_r;
  logic [15:0]        mat_r;
  logic [DATE_W-1:0]  date_r;
  logic [SUM_W-1:0]   sum_b;
  logic [SUM_W-1:0]   sum_u;
  logic [15:0]        fb_last;
  logic [15:0]        fu_last;
  logic               oor_r;
  logic               pend;
  logic               pend_in;
  logic [PROD_W-1:0]  prod_r;
  logic [PRICE_W-1:0] q_b;
  logic [PRICE_W-1:0] q_u;
  div_kind_t          kind_r;

  logic [3:0]         cpy_adj;
  logic [8:0]         step_sel;
  logic [DATE_W-1:0]  off;
  logic               in_range;
  logic [DATE_W-1:0]  load_off;
  logic               ram_we;
  logic [31:0]        ram_rdata;
  logic [15:0]        fac_b;
  logic [15:0]        fac_u;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;
  logic [NUM_W-1:0]   div_quo;
  logic [DEN_W-1:0]   div_rem;
  logic [DATE_W-1:0]  first_date;
  logic [PRICE_W-1:0] pb;
  logic [PRICE_W-1:0] pu;
  logic [PRICE_W:0]   dv;

  // A frequency of zero is taken as one payment a year.
  always_comb begin
    cpy_adj = (pay_freq == 4'd0) ? 4'd1 : pay_freq;
    unique case (cpy_adj)
      4'd1:    step_sel = 9'(YEAR_DAYS / 1);
      4'd2:    step_sel = 9'(YEAR_DAYS / 2);
      4'd3:    step_sel = 9'(YEAR_DAYS / 3);
      4'd4:    step_sel = 9'(YEAR_DAYS / 4);
      4'd5:    step_sel = 9'(YEAR_DAYS / 5);
      4'd6:    step_sel = 9'(YEAR_DAYS / 6);
      4'd7:    step_sel = 9'(YEAR_DAYS / 7);
      4'd8:    step_sel = 9'(YEAR_DAYS / 8);
      4'd9:    step_sel = 9'(YEAR_DAYS / 9);
      4'd10:   step_sel = 9'(YEAR_DAYS / 10);
      4'd11:   step_sel = 9'(YEAR_DAYS / 11);
      4'd12:   step_sel = 9'(YEAR_DAYS / 12);
      4'd13:   step_sel = 9'(YEAR_DAYS / 13);
      4'd14:   step_sel = 9'(YEAR_DAYS / 14);
      4'd15:   step_sel = 9'(YEAR_DAYS / 15);
      default: step_sel = 9'(YEAR_DAYS);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      today <= '0;
    end else if (cfg_we) begin
      today <= cfg_data;
    end
  end

  // Curve store: the bumped factor sits in the upper half of each word.
  always_comb begin
    load_off = DATE_W'(day_offset);
    ram_we   = cmd.write_entry && ({1'b0, load_off} < DEPTH_W);
    off      = date_r - DATE_W'(today);
    in_range = {1'b0, off} < DEPTH_W;
  end

  bpdc_ram #(
    .WIDTH (32),
    .DEPTH (CURVE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_off[AW-1:0]),
    .wdata ({discount_factor_bumped, discount_factor}),
    .raddr (off[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Divider operands: the rounding offset is half of 100 times the frequency.
  always_comb begin
    unique case (cmd.div_kind)
      DIV_FIRST: begin
        div_num = NUM_W'(DATE_W'(today) - DATE_W'(start_r) + DATE_W'(step_r) - DATE_W'(1));
        div_den = DEN_W'(step_r);
      end
      DIV_BASE, DIV_BUMP: begin
        div_num = NUM_W'(prod_r) + NUM_W'(cpy_r) * NUM_W'(50);
        div_den = DEN_W'(cpy_r) * DEN_W'(100);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  bpdc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // The remainder of the rounded-up count gives the first date at or after today.
  always_comb begin
    first_date = DATE_W'(today) + DATE_W'(step_r) - DATE_W'(1) - DATE_W'(div_rem[8:0]);
    fac_b      = pend_in ? ram_rdata[15:0] : 16'd0;
    fac_u      = pend_in ? ram_rdata[31:16] : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.walk_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      coupon_r <= coupon_centipct;
      cpy_r    <= cpy_adj;
      step_r   <= step_sel;
      start_r  <= anchor_day;
      mat_r    <= maturity_day;
      date_r   <= DATE_W'(anchor_day);
      sum_b    <= '0;
      sum_u    <= '0;
      oor_r    <= 1'b0;
    end else begin
      if (cmd.walk_step) begin
        pend_in <= in_range;
        date_r  <= date_r + DATE_W'(step_r);
        if (!in_range) begin
          oor_r <= 1'b1;
        end
      end
      if (pend) begin
        sum_b   <= sum_b + SUM_W'(fac_b);
        sum_u   <= sum_u + SUM_W'(fac_u);
        fb_last <= fac_b;
        fu_last <= fac_u;
      end
      if (div_done && kind_r == DIV_FIRST) begin
        date_r <= first_date;
      end
    end
    if (cmd.div_start) begin
      kind_r <= cmd.div_kind;
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(coupon_r) * PROD_W'(cmd.mul_sel ? sum_u : sum_b);
    end
    if (div_done && kind_r == DIV_BASE) begin
      q_b <= div_quo[PRICE_W-1:0];
    end
    if (div_done && kind_r == DIV_BUMP) begin
      q_u <= div_quo[PRICE_W-1:0];
    end
  end

  always_comb begin
    pb = q_b + PRICE_W'(fb_last) * PRICE_W'(100);
    pu = q_u + PRICE_W'(fu_last) * PRICE_W'(100);
    dv = {1'b0, pb} - {1'b0, pu};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      price        <= (|pb[PRICE_W-1:32]) ? 32'hFFFF_FFFF : pb[31:0];
      out_of_range <= oor_r;
      priority if (!dv[PRICE_W] && (|dv[PRICE_W-1:31])) begin
        dv01 <= 32'sh7FFF_FFFF;
      end else if (dv[PRICE_W] && !(&dv[PRICE_W-1:31])) begin
        dv01 <= 32'sh8000_0000;
      end else begin
        dv01 <= $signed(dv[31:0]);
      end
    end
  end

  always_comb begin
    status.before_today = start_r < today;
    status.last_date    = date_r >= DATE_W'(mat_r);
    status.div_done     = div_done;
  end

endmodule

// File: design/bpdc_ctrl.sv
module bpdc_ctrl import bpdc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    func,
  input  status_t status,
  output logic    busy,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (start && func) state_next = ST_CHECK;
      ST_CHECK:      state_next = status.before_today ? ST_FIRST_WAIT : ST_WALK;
      ST_FIRST_WAIT: if (status.div_done) state_next = ST_WALK;
      ST_WALK:       if (status.last_date) state_next = ST_DRAIN;
      ST_DRAIN:      state_next = ST_MUL_B;
      ST_MUL_B:      state_next = ST_GO_B;
      ST_GO_B:       state_next = ST_WAIT_B;
      ST_WAIT_B:     if (status.div_done) state_next = ST_MUL_U;
      ST_MUL_U:      state_next = ST_GO_U;
      ST_GO_U:       state_next = ST_WAIT_U;
      ST_WAIT_U:     if (status.div_done) state_next = ST_FINISH;
      ST_FINISH:     state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy            = state != ST_IDLE;
    cmd             = '0;
    cmd.div_kind    = DIV_FIRST;
    unique case (state)
      ST_IDLE: begin
        cmd.capture     = start && func;
        cmd.write_entry = start && !func;
      end
      ST_CHECK: begin
        cmd.div_start = status.before_today;
        cmd.div_kind  = DIV_FIRST;
      end
      ST_WALK:   cmd.walk_step = 1'b1;
      ST_MUL_B: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 1'b0;
      end
      ST_GO_B: begin
        cmd.div_start = 1'b1;
        cmd.div_kind  = DIV_BASE;
      end
      ST_WAIT_B: cmd.div_kind = DIV_BASE;
      ST_MUL_U: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 1'b1;
      end
      ST_GO_U: begin
        cmd.div_start = 1'b1;
        cmd.div_kind  = DIV_BUMP;
      end
      ST_WAIT_U: cmd.div_kind = DIV_BUMP;
      ST_FINISH: cmd.finish = 1'b1;
      default: ;
    endcase
  end

endmodule

// File: design/bond_price_discount_curve.sv
// Bond pricer against a stored discount curve and its one-basis-point bumped twin. A word
// is taken when start is high and busy is low. A load word (func 0) writes one curve entry
// in that cycle and leaves busy low, so loads can follow back to back. A price word
// (func 1) holds busy high while it is priced. When the start date is before today, a
// shared divider of 48 steps first finds the first date on or after today; the walk then
// reads one date per cycle from the curve memory, and the same divider then runs once
// for each curve. The result word appears on price, dv01 and out_of_range for exactly
// one cycle with done high, in the first cycle with busy low; the receiver cannot stall
// it, so it must be taken in that cycle. The today register may only be written while
// busy is low.
module bond_price_discount_curve import bpdc_pkg::*; #(
  parameter int CURVE_DEPTH = 4096,
  parameter int YEAR_DAYS   = 365
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  input  logic               func,
  input  logic [11:0]        day_offset,
  input  logic [15:0]        discount_factor,
  input  logic [15:0]        discount_factor_bumped,
  input  logic [13:0]        coupon_centipct,
  input  logic [3:0]         pay_freq,
  input  logic [15:0]        anchor_day,
  input  logic [15:0]        maturity_day,
  output logic               done,
  output logic [31:0]        price,
  output logic signed [31:0] dv01,
  output logic               out_of_range
);

  cmd_t    cmd;
  status_t status;

  bpdc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  bpdc_datapath #(
    .CURVE_DEPTH (CURVE_DEPTH),
    .YEAR_DAYS   (YEAR_DAYS)
  ) u_dp (
    .clk                    (clk),
    .rst                    (rst),
    .cmd                    (cmd),
    .status                 (status),
    .cfg_we                 (cfg_we),
    .cfg_data               (cfg_data),
    .day_offset             (day_offset),
    .discount_factor        (discount_factor),
    .discount_factor_bumped (discount_factor_bumped),
    .coupon_centipct        (coupon_centipct),
    .pay_freq               (pay_freq),
    .anchor_day             (anchor_day),
    .maturity_day           (maturity_day),
    .done                   (done),
    .price                  (price),
    .dv01                   (dv01),
    .out_of_range           (out_of_range)
  );

endmodule

// File: design/bpdc_checker.sv
module bpdc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic func,
  input logic done
);

  // A price word always keeps the block busy in the next cycle.
  a_price_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func) |=> busy)
    else $error("price word accepted but block not busy");

  // A load word returns no result and does not occupy the block.
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !func) |=> (!busy && !done))
    else $error("load word made the block busy or produced a result");

  // A result word follows the end of a busy period.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result word without a preceding busy period");

  // Results are single-cycle strobes.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

endmodule

bind bond_price_discount_curve bpdc_checker u_chk (.*);
